/* src/xsr_pkg.sv */
// Shared types and constants for the xoshiro256** byte generator.
package xsr_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned BYTES_W = 4;
  localparam int unsigned MAX_BYTES = 512;

  localparam logic [WORD_W-1:0] SEED_SUBST = 64'hdeadbeefcafe1234;
  localparam logic [WORD_W-1:0] SM_GAMMA   = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SM_MUL1    = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] SM_MUL2    = 64'h94d049bb133111eb;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_SOURCE = 1'b1;

  localparam logic KIND_RESEED = 1'b0;
  localparam logic KIND_FILL   = 1'b1;

  typedef struct packed {
    logic               fill;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    SD_IDLE,
    SD_ADD,
    SD_MUL1,
    SD_MUL2
  } seed_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEED,
    BK_FILL
  } back_state_e;

endpackage

/* src/xsr_front.sv */
// Front end: accepts items, clamps the byte count and queues commands.
module xsr_front #(
  parameter int unsigned MaxBytes = xsr_pkg::MAX_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [xsr_pkg::COUNT_W-1:0] byte_count_i,
  output logic                        cmd_valid_o,
  output xsr_pkg::cmd_t               cmd_o,
  input  logic                        cmd_ready_i
);

  localparam logic [xsr_pkg::COUNT_W-1:0] CountMax = xsr_pkg::COUNT_W'(MaxBytes);

  xsr_pkg::cmd_t q_mem_q [2];
  xsr_pkg::cmd_t cmd_in;
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  always_comb begin
    cmd_in.fill  = (kind_i == xsr_pkg::KIND_FILL);
    cmd_in.count = (byte_count_i > CountMax) ? CountMax : byte_count_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* src/xsr_seed.sv */
// Splitmix64 seed expander with one shared 32x32 multiplier.
module xsr_seed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [xsr_pkg::WORD_W-1:0] seed_i,
  output logic                       done_o,
  output logic [xsr_pkg::WORD_W-1:0] words_o [4]
);

  xsr_pkg::seed_state_e state_q, state_d;

  logic [1:0]  ph_q, ph_d;
  logic [1:0]  idx_q, idx_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] z_q, z_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] words_q [4];
  logic        done_q, done_d;
  logic        wr_word;
  logic [63:0] wr_data;

  logic [63:0] mul_b;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;
  logic [63:0] prod_sum;
  logic [63:0] acc_sum;

  assign mul_b    = (state_q == xsr_pkg::SD_MUL1) ? xsr_pkg::SM_MUL1 : xsr_pkg::SM_MUL2;
  assign op_a     = (ph_q == 2'd2) ? z_q[63:32] : z_q[31:0];
  assign op_b     = (ph_q == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign pp       = op_a * op_b;
  assign prod_sum = (ph_q == 2'd0) ? pp : prod_q + {pp[31:0], 32'd0};
  assign acc_sum  = acc_q + xsr_pkg::SM_GAMMA;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xsr_pkg::SD_IDLE: begin
        if (start_i) state_d = xsr_pkg::SD_ADD;
      end
      xsr_pkg::SD_ADD: begin
        state_d = xsr_pkg::SD_MUL1;
      end
      xsr_pkg::SD_MUL1: begin
        if (ph_q == 2'd2) state_d = xsr_pkg::SD_MUL2;
      end
      xsr_pkg::SD_MUL2: begin
        if (ph_q == 2'd2) state_d = (idx_q == 2'd3) ? xsr_pkg::SD_IDLE : xsr_pkg::SD_ADD;
      end
      default: state_d = xsr_pkg::SD_IDLE;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    z_d     = z_q;
    prod_d  = prod_q;
    ph_d    = ph_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    wr_word = 1'b0;
    wr_data = prod_sum ^ (prod_sum >> 31);
    unique case (state_q)
      xsr_pkg::SD_IDLE: begin
        if (start_i) begin
          acc_d = (seed_i == '0) ? xsr_pkg::SEED_SUBST : seed_i;
          idx_d = 2'd0;
          ph_d  = 2'd0;
        end
      end
      xsr_pkg::SD_ADD: begin
        acc_d = acc_sum;
        z_d   = acc_sum ^ (acc_sum >> 30);
        ph_d  = 2'd0;
      end
      xsr_pkg::SD_MUL1: begin
        prod_d = prod_sum;
        ph_d   = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          z_d  = prod_sum ^ (prod_sum >> 27);
          ph_d = 2'd0;
        end
      end
      xsr_pkg::SD_MUL2: begin
        prod_d = prod_sum;
        ph_d   = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          ph_d    = 2'd0;
          wr_word = 1'b1;
          idx_d   = idx_q + 2'd1;
          done_d  = (idx_q == 2'd3);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    z_q    <= z_d;
    prod_q <= prod_d;
    if (wr_word) begin
      words_q[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xsr_pkg::SD_IDLE;
      ph_q    <= 2'd0;
      idx_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  assign done_o  = done_q;
  assign words_o = words_q;

endmodule

/* src/xsr_back.sv */
// Back end: runs commands, steps the xoshiro256** state, drives the result register.
module xsr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  xsr_pkg::cmd_t               cmd_i,
  output logic                        cmd_ready_o,
  output logic                        seed_start_o,
  input  logic                        seed_done_i,
  input  logic [xsr_pkg::WORD_W-1:0]  seed_words_i [4],
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xsr_pkg::WORD_W-1:0]  word_o,
  output logic [xsr_pkg::BYTES_W-1:0] bytes_valid_o,
  output logic                        status_o,
  output logic                        last_o
);

  xsr_pkg::back_state_e state_q, state_d;

  logic [63:0]                 gen_q [4];
  logic [63:0]                 gen_next [4];
  logic                        seeded_q, seeded_d;
  logic [xsr_pkg::COUNT_W-1:0] rem_q, rem_d;

  logic                        out_valid_q, out_valid_d;
  logic [63:0]                 word_q;
  logic [xsr_pkg::BYTES_W-1:0] bytes_q;
  logic                        status_q, last_q;

  logic                        out_free;
  logic                        emit, adv, load_seed;
  logic [63:0]                 emit_word;
  logic [xsr_pkg::BYTES_W-1:0] emit_bytes;
  logic                        emit_status, emit_last;
  logic                        rem_last;
  logic [xsr_pkg::BYTES_W-1:0] chunk;

  logic [63:0] t17, n0, n1, n2, n3;
  logic [63:0] a5, r7, res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rem_last = (rem_q <= xsr_pkg::COUNT_W'(8));
  assign chunk    = rem_last ? rem_q[xsr_pkg::BYTES_W-1:0] : xsr_pkg::BYTES_W'(8);

  always_comb begin
    a5  = gen_q[1] + (gen_q[1] << 2);
    r7  = {a5[56:0], a5[63:57]};
    res = r7 + (r7 << 3);
    t17 = gen_q[1] << 17;
    n2  = gen_q[2] ^ gen_q[0];
    n3  = gen_q[3] ^ gen_q[1];
    n1  = gen_q[1] ^ n2;
    n0  = gen_q[0] ^ n3;
    gen_next[0] = n0;
    gen_next[1] = n1;
    gen_next[2] = n2 ^ t17;
    gen_next[3] = {n3[18:0], n3[63:19]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xsr_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.fill) begin
            state_d = xsr_pkg::BK_SEED;
          end else if (seeded_q && cmd_i.count != '0) begin
            state_d = xsr_pkg::BK_FILL;
          end
        end
      end
      xsr_pkg::BK_SEED: begin
        if (seed_done_i) state_d = xsr_pkg::BK_IDLE;
      end
      xsr_pkg::BK_FILL: begin
        if (out_free && rem_last) state_d = xsr_pkg::BK_IDLE;
      end
      default: state_d = xsr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o  = 1'b0;
    seed_start_o = 1'b0;
    load_seed    = 1'b0;
    seeded_d     = seeded_q;
    rem_d        = rem_q;
    emit         = 1'b0;
    adv          = 1'b0;
    emit_word    = '0;
    emit_bytes   = '0;
    emit_status  = xsr_pkg::STATUS_OK;
    emit_last    = 1'b1;
    unique case (state_q)
      xsr_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.fill) begin
            cmd_ready_o  = 1'b1;
            seed_start_o = 1'b1;
          end else if (!seeded_q) begin
            cmd_ready_o = out_free;
            emit        = out_free;
            emit_status = xsr_pkg::STATUS_NO_SOURCE;
          end else if (cmd_i.count == '0) begin
            cmd_ready_o = out_free;
            emit        = out_free;
          end else begin
            cmd_ready_o = 1'b1;
            rem_d       = cmd_i.count;
          end
        end
      end
      xsr_pkg::BK_SEED: begin
        if (seed_done_i) begin
          load_seed = 1'b1;
          seeded_d  = 1'b1;
        end
      end
      xsr_pkg::BK_FILL: begin
        if (out_free) begin
          emit       = 1'b1;
          adv        = 1'b1;
          emit_word  = res;
          emit_bytes = chunk;
          emit_last  = rem_last;
          rem_d      = rem_q - xsr_pkg::COUNT_W'(chunk);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (load_seed) begin
      gen_q <= seed_words_i;
    end else if (adv) begin
      gen_q <= gen_next;
    end
    if (emit) begin
      word_q   <= emit_word;
      bytes_q  <= emit_bytes;
      status_q <= emit_status;
      last_q   <= emit_last;
    end
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xsr_pkg::BK_IDLE;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = word_q;
  assign bytes_valid_o = bytes_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

/* src/xoshiro256ss_byte_generator.sv */
// Top level of the xoshiro256** byte generator with splitmix64 seeding.
//
// Input channel (in_valid_i / in_stall_o): kind_i = 0 reseeds from the seed
// register, kind_i = 1 requests byte_count_i random bytes (clamped to MaxBytes).
// Config channel (cfg_valid_i / cfg_ready_o): writes the 64-bit seed; always ready.
// Output channel (out_valid_o / out_stall_i): one 64-bit word per started group
// of 8 bytes, bytes_valid_o low bytes valid, last_o on the final word.
// A fill before any reseed gives one word with status_o = 1; a zero count
// gives one empty word with last_o set.
// A fill passes the command queue and the back end's IDLE state before its first
// word reaches the output register. Throughput: one word per cycle while
// out_stall_i is low, so a request of N bytes gives ceil(N/8) words.
// Reseed runs four splitmix64 steps on one 32x32 multiplier, each through the
// ADD, MUL1 and MUL2 states; fills queued behind it wait.
// A two-entry command queue lets items be taken while the back end works.
// Reset clears the seed register and the seeded flag and empties the queue.
// While out_stall_i is high and a word is valid, the result register holds and no new word is emitted.
module xoshiro256ss_byte_generator #(
  parameter int unsigned MaxBytes = xsr_pkg::MAX_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [xsr_pkg::WORD_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [xsr_pkg::COUNT_W-1:0] byte_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xsr_pkg::WORD_W-1:0]  word_o,
  output logic [xsr_pkg::BYTES_W-1:0] bytes_valid_o,
  output logic                        status_o,
  output logic                        last_o
);

  logic [xsr_pkg::WORD_W-1:0] seed_q;
  logic                       cmd_valid;
  xsr_pkg::cmd_t              cmd;
  logic                       cmd_ready;
  logic                       seed_start;
  logic                       seed_done;
  logic [xsr_pkg::WORD_W-1:0] seed_words [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_data_i;
    end
  end

  xsr_front #(
    .MaxBytes(MaxBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_count_i (byte_count_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  xsr_seed u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_start),
    .seed_i  (seed_q),
    .done_o  (seed_done),
    .words_o (seed_words)
  );

  xsr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .seed_start_o  (seed_start),
    .seed_done_i   (seed_done),
    .seed_words_i  (seed_words),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_o        (word_o),
    .bytes_valid_o (bytes_valid_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  a_no_source_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && bytes_valid_o == '0 && word_o == '0)
    else $error("no-source result malformed");

  a_full_unless_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> bytes_valid_o == xsr_pkg::BYTES_W'(8) && status_o == 1'b0)
    else $error("non-final word not full");

  a_bytes_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bytes_valid_o <= xsr_pkg::BYTES_W'(8))
    else $error("bytes_valid out of range");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the xoshiro256** byte generator with splitmix64 seeding.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [xsr_pkg::WORD_W-1:0]  word;
    logic [xsr_pkg::BYTES_W-1:0] nbytes;
    logic                        status;
    logic                        last;
  } gen_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [xsr_pkg::WORD_W-1:0]  cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        kind = xsr_pkg::KIND_RESEED;
  logic [xsr_pkg::COUNT_W-1:0] byte_count = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [xsr_pkg::WORD_W-1:0]  word;
  logic [xsr_pkg::BYTES_W-1:0] bytes_valid;
  logic                        status;
  logic                        last;

  xsr_pkg::cmd_t cmd_pending[$];
  gen_result_t   words_due[$];
  bit            in_busy = 1'b0;
  bit            calm = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;

  logic [xsr_pkg::WORD_W-1:0] seed_shadow = '0;
  logic [xsr_pkg::WORD_W-1:0] gen_state[4] = '{default: '0};
  bit                         gen_seeded = 1'b0;

  xoshiro256ss_byte_generator u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .byte_count_i  (byte_count),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .word_o        (word),
    .bytes_valid_o (bytes_valid),
    .status_o      (status),
    .last_o        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [xsr_pkg::WORD_W-1:0] rotl(logic [xsr_pkg::WORD_W-1:0] x,
                                                       int unsigned k);
    return (x << k) | (x >> (xsr_pkg::WORD_W - k));
  endfunction

  function automatic logic [xsr_pkg::WORD_W-1:0] splitmix_next(
      inout logic [xsr_pkg::WORD_W-1:0] acc);
    logic [xsr_pkg::WORD_W-1:0] z;
    acc = acc + xsr_pkg::SM_GAMMA;
    z = acc;
    z = (z ^ (z >> 30)) * xsr_pkg::SM_MUL1;
    z = (z ^ (z >> 27)) * xsr_pkg::SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [xsr_pkg::WORD_W-1:0] xoshiro_next();
    logic [xsr_pkg::WORD_W-1:0] res;
    logic [xsr_pkg::WORD_W-1:0] t;
    res = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
    t = gen_state[1] << 17;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= t;
    gen_state[3] = rotl(gen_state[3], 45);
    return res;
  endfunction

  task automatic predict_words(xsr_pkg::cmd_t c);
    logic [xsr_pkg::WORD_W-1:0]  acc;
    logic [xsr_pkg::COUNT_W-1:0] left;
    logic [xsr_pkg::COUNT_W-1:0] chunk;
    if (c.fill == xsr_pkg::KIND_RESEED) begin
      acc = (seed_shadow == '0) ? xsr_pkg::SEED_SUBST : seed_shadow;
      for (int i = 0; i < 4; i++) gen_state[i] = splitmix_next(acc);
      gen_seeded = 1'b1;
    end else if (!gen_seeded) begin
      words_due.push_back('{word: '0, nbytes: '0, status: xsr_pkg::STATUS_NO_SOURCE,
                            last: 1'b1});
    end else begin
      left = (c.count > xsr_pkg::MAX_BYTES) ? xsr_pkg::COUNT_W'(xsr_pkg::MAX_BYTES) : c.count;
      if (left == 0) begin
        words_due.push_back('{word: '0, nbytes: '0, status: xsr_pkg::STATUS_OK, last: 1'b1});
      end
      while (left > 0) begin
        chunk = (left < 8) ? left : xsr_pkg::COUNT_W'(8);
        left -= chunk;
        words_due.push_back('{word: xoshiro_next(), nbytes: xsr_pkg::BYTES_W'(chunk),
                              status: xsr_pkg::STATUS_OK, last: (left == 0)});
      end
    end
  endtask

  task automatic note_error(string msg);
    errors++;
    if (errors <= 30) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_busy) begin
      if (rst_n && cmd_pending.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
        in_valid   <= 1'b1;
        kind       <= cmd_pending[0].fill;
        byte_count <= cmd_pending[0].count;
        in_busy = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input transfer -> prediction
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_words(cmd_pending.pop_front());
      in_busy = 1'b0;
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  // result monitor
  always @(posedge clk) begin
    gen_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        note_error($sformatf("unexpected result word=%h", word));
      end else begin
        e = words_due.pop_front();
        if (word !== e.word)
          note_error($sformatf("word exp=%h got=%h", e.word, word));
        if (bytes_valid !== e.nbytes)
          note_error($sformatf("bytes_valid exp=%0d got=%0d", e.nbytes, bytes_valid));
        if (status !== e.status)
          note_error($sformatf("status exp=%0b got=%0b", e.status, status));
        if (last !== e.last)
          note_error($sformatf("last exp=%0b got=%0b", e.last, last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_seed(logic [xsr_pkg::WORD_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_fill(int unsigned n);
    cmd_pending.push_back('{fill: xsr_pkg::KIND_FILL, count: xsr_pkg::COUNT_W'(n)});
  endtask

  task automatic queue_reseed();
    cmd_pending.push_back('{fill: xsr_pkg::KIND_RESEED,
                            count: xsr_pkg::COUNT_W'($urandom_range(1023, 0))});
  endtask

  task automatic settle();
    while (cmd_pending.size() > 0 || in_busy || words_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) queue_reseed();
      else if (r < 18) queue_fill($urandom_range(1023, 0));
      else if (r < 35) queue_fill($urandom_range(512, 65));
      else if (r < 70) queue_fill($urandom_range(64, 0));
      else queue_fill($urandom_range(8, 0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fills before any reseed: no source
    queue_fill(5);
    queue_fill(0);
    queue_fill(1023);
    settle();

    // zero seed takes the substitute; boundary counts; reseed restarts sequence
    write_seed('0);
    queue_reseed();
    queue_fill(0);
    queue_fill(1);
    queue_fill(7);
    queue_fill(8);
    queue_fill(9);
    queue_fill(512);
    queue_fill(513);
    queue_fill(1023);
    queue_fill(15);
    queue_reseed();
    queue_fill(16);
    settle();

    write_seed('1);
    queue_reseed();
    queue_fill(24);
    queue_fill(600);
    settle();

    write_seed(64'd1);
    queue_reseed();
    queue_fill(40);
    settle();

    // long receiver hold while the sender keeps offering
    write_seed({$urandom, $urandom});
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    queue_reseed();
    queue_random(95);
    settle();

    calm = 1'b1;
    write_seed('0);
    queue_reseed();
    queue_random(95);
    settle();
    calm = 1'b0;

    write_seed({$urandom, $urandom});
    queue_reseed();
    queue_random(95);
    settle();

    write_seed(64'h8000_0000_0000_0000);
    queue_reseed();
    queue_random(95);
    settle();

    if (words_due.size() != 0) note_error("results still expected at end of run");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/xsr_pkg.sv
src/xsr_front.sv
src/xsr_seed.sv
src/xsr_back.sv
src/xoshiro256ss_byte_generator.sv
bench/tb.sv
